@@ rtl/ipv_pkg.sv @@
// Shared types, constants and state encoding of the incremental PID valve pulse unit.
package ipv_pkg;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_GAIN_P          = 3'd0;
  localparam cfg_idx_t REG_INTEGRAL_TIME   = 3'd1;
  localparam cfg_idx_t REG_DERIVATIVE_TIME = 3'd2;
  localparam cfg_idx_t REG_CYCLE_TIME      = 3'd3;
  localparam cfg_idx_t REG_VALVE_TRAVEL    = 3'd4;
  localparam cfg_idx_t REG_DEAD_BAND       = 3'd5;

  // Register reset values.
  localparam logic signed [15:0] GAIN_P_RST    = 16'sd256;
  localparam logic [16:0]        TI_RST        = 17'd40;
  localparam logic [16:0]        TD_RST        = 17'd40;
  localparam logic [17:0]        CYC_RST       = 18'd600;
  localparam logic [17:0]        VALVE_RST     = 18'd3000;
  localparam logic [15:0]        DEAD_BAND_RST = 16'd8;

  // Limits applied when the registers are used.
  localparam logic signed [15:0] KP_LIMIT  = 16'sd25344;
  localparam logic [16:0]        TI_MIN    = 17'd10;
  localparam logic [16:0]        TI_MAX    = 17'd99990;
  localparam logic [16:0]        TD_MAX    = 17'd99990;
  localparam logic [17:0]        CYC_MIN   = 18'd10;
  localparam logic [17:0]        CYC_MAX   = 18'd180000;
  localparam logic [17:0]        VALVE_MIN = 18'd3000;
  localparam logic [17:0]        VALVE_MAX = 18'd250000;

  // Clamped configuration as seen by the datapath.
  typedef struct packed {
    logic        kp_neg;
    logic [14:0] kp_mag;
    logic [16:0] ti;
    logic [16:0] td;
    logic [17:0] cyc;
    logic [17:0] valve;
    logic [15:0] dead_band;
  } cfg_t;

  // Shared multiplier.
  localparam int unsigned MUL_A_W = 19;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  typedef logic [MUL_A_W-1:0] mul_a_t;
  typedef logic [MUL_B_W-1:0] mul_b_t;
  typedef logic [MUL_P_W-1:0] mul_p_t;

  // Shared divider, two quotient bits per cycle.
  localparam int unsigned DIV_N_W    = 36;
  localparam int unsigned DIV_D_W    = 18;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_N_W / DIV_BITS);
  typedef logic [DIV_N_W-1:0] div_n_t;
  typedef logic [DIV_D_W-1:0] div_d_t;

  typedef struct packed {
    logic   start;
    div_n_t dividend;
    div_d_t divisor;
  } div_req_t;

  // Output scaling: 409600 = 2^14 * 25.
  localparam logic [18:0]  SCALE_DIV   = 19'd409600;
  localparam int unsigned  SCALE_SHIFT = 14;
  localparam div_d_t       SCALE_ODD   = 18'd25;

  // Width of the signed PID sum.
  localparam int unsigned SUM_W = 34;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_INT,
    S_DIV_INT,
    S_WAIT_INT,
    S_MUL_DER,
    S_DIV_DER,
    S_WAIT_DER,
    S_SUM,
    S_MUL_GAIN,
    S_CHECK,
    S_DIV_VALVE,
    S_WAIT_VALVE,
    S_DONE
  } state_e;

endpackage

@@ rtl/ipv_in_if.sv @@
// Input channel carrying setpoint and measurement transactions.
interface ipv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_temp;
  logic signed [15:0] measured_temp;

  modport source (output valid, output target_temp, output measured_temp, input ready);
  modport sink (input valid, input target_temp, input measured_temp, output ready);
endinterface

@@ rtl/ipv_out_if.sv @@
// Output channel carrying valve pulse transactions.
interface ipv_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] pulse_ms;

  modport source (output valid, output pulse_ms, input ready);
  modport sink (input valid, input pulse_ms, output ready);
endinterface

@@ rtl/incremental_pid_valve_pulse_unit.sv @@
// Top level of the incremental PID valve pulse unit: sequencer and datapath registers.
//
// Usage: each transaction on in_i carries a setpoint and a measurement in 1/16 degree.
// For every input transaction the block returns exactly one transaction on out_o that
// holds the signed valve drive time in milliseconds (positive opens, negative closes).
// Both channels use a valid/ready handshake; a transaction moves on a rising clock edge
// where valid and ready are both high. Configuration registers are written through the
// plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must write them only while
// no transaction is in flight, as the block itself does not enforce this. Inside the dead band
// the block goes straight to its done state and loads the result into the output
// register from there. Outside it the work runs through one shared multiplier and
// one shared divider; each of the up to three quotients takes 18 divider steps of two
// bits, and the last division is skipped when the pulse saturates. in_i.ready is high
// only while idle, so a new transaction is taken only after the last result is loaded.
// A finished result sits in an output register; the next input transaction may be
// accepted while it waits. If the receiver stalls, the result is held stable and the
// next result waits inside the block until the register frees up.
// Reset clears the error history, returns the registers to their defaults and leaves
// the block idle with no result pending.
module incremental_pid_valve_pulse_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  ipv_pkg::cfg_idx_t  cfg_idx_i,
  input  ipv_pkg::cfg_data_t cfg_data_i,
  ipv_in_if.sink             in_i,
  ipv_out_if.source          out_o
);
  import ipv_pkg::*;

  cfg_t     cfg;
  state_e   state_q;
  state_e   state_d;

  logic     accept;
  logic     out_free;
  logic     out_load;

  // Error history (the controller's state) and the working copies of one transaction.
  logic signed [16:0] last_err_q;
  logic signed [16:0] older_err_q;
  logic signed [16:0] e1_in;
  logic signed [16:0] e1_neg;
  logic [15:0]        e1_in_mag;
  logic signed [16:0] e1_q;
  logic signed [16:0] e2_q;
  logic signed [16:0] e3_q;
  logic signed [16:0] e2_neg;
  logic [15:0]        e2_mag;

  logic signed [18:0] diff_q;
  logic signed [18:0] diff_neg;
  logic [17:0]        diff_mag;

  logic signed [SUM_W-1:0] quot_mag;
  logic signed [SUM_W-1:0] qi_q;
  logic signed [SUM_W-1:0] qd_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [SUM_W-1:0] sum_neg;
  logic [SUM_W-2:0]        sum_mag;
  logic [18:0]             sum_clamp;

  logic               neg_q;
  logic [17:0]        res_q;
  logic               sat;
  logic [21:0]        res_x10;
  logic               short_pulse;
  logic signed [18:0] pulse_mag;
  logic signed [18:0] pulse;

  logic               out_valid_q;
  logic signed [18:0] out_pulse_q;

  mul_a_t   mul_a;
  mul_b_t   mul_b;
  mul_p_t   mul_p;
  div_req_t div_req;
  logic     div_done;
  div_n_t   div_quot;

  ipv_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ipv_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  ipv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Handshakes.
  assign in_i.ready   = (state_q == S_IDLE);
  assign accept       = in_i.valid && (state_q == S_IDLE);
  assign out_free     = !out_valid_q || out_o.ready;
  assign out_load     = (state_q == S_DONE) && out_free;
  assign out_o.valid    = out_valid_q;
  assign out_o.pulse_ms = out_pulse_q;

  // Error of the incoming transaction and magnitudes of the working values.
  always_comb begin
    e1_in     = 17'(in_i.target_temp) - 17'(in_i.measured_temp);
    e1_neg    = -e1_in;
    e1_in_mag = e1_in[16] ? e1_neg[15:0] : e1_in[15:0];
    e2_neg    = -e2_q;
    e2_mag    = e2_q[16] ? e2_neg[15:0] : e2_q[15:0];
    diff_neg  = -diff_q;
    diff_mag  = diff_q[18] ? diff_neg[17:0] : diff_q[17:0];
    sum_neg   = -sum_q;
    sum_mag   = sum_q[SUM_W-1] ? sum_neg[SUM_W-2:0] : sum_q[SUM_W-2:0];
    // Any sum at or above the scale divisor saturates once the gain is nonzero,
    // so the multiplier only needs to see it clipped there.
    sum_clamp = (sum_mag >= (SUM_W-1)'(SCALE_DIV)) ? SCALE_DIV : sum_mag[18:0];
    quot_mag  = {1'b0, div_quot[SUM_W-2:0]};
    sat       = (mul_p >= MUL_P_W'(SCALE_DIV));
  end

  // Final shaping: pulses shorter than a tenth of the valve travel are dropped.
  always_comb begin
    res_x10     = 22'({res_q, 3'b000}) + 22'({res_q, 1'b0});
    short_pulse = (res_x10 < 22'(cfg.valve));
    pulse_mag   = short_pulse ? '0 : $signed({1'b0, res_q});
    pulse       = neg_q ? -pulse_mag : pulse_mag;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (e1_in_mag > cfg.dead_band) ? S_MUL_INT : S_DONE;
        end
      end
      S_MUL_INT:  state_d = S_DIV_INT;
      S_DIV_INT:  state_d = S_WAIT_INT;
      S_WAIT_INT: begin
        if (div_done) begin
          state_d = S_MUL_DER;
        end
      end
      S_MUL_DER:  state_d = S_DIV_DER;
      S_DIV_DER:  state_d = S_WAIT_DER;
      S_WAIT_DER: begin
        if (div_done) begin
          state_d = S_SUM;
        end
      end
      S_SUM:      state_d = S_MUL_GAIN;
      S_MUL_GAIN: state_d = S_CHECK;
      S_CHECK:    state_d = sat ? S_DONE : S_DIV_VALVE;
      S_DIV_VALVE: state_d = S_WAIT_VALVE;
      S_WAIT_VALVE: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Operands for the shared multiplier and divider.
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_N_W'(mul_p[MUL_P_W-2:0]);
    div_req.divisor  = cfg.cyc;
    case (state_q)
      S_MUL_INT: begin
        mul_a = MUL_A_W'(e2_mag);
        mul_b = cfg.cyc;
      end
      S_DIV_INT: begin
        div_req.start   = 1'b1;
        div_req.divisor = DIV_D_W'(cfg.ti);
      end
      S_MUL_DER: begin
        mul_a = MUL_A_W'(diff_mag);
        mul_b = MUL_B_W'(cfg.td);
      end
      S_DIV_DER: begin
        div_req.start   = 1'b1;
        div_req.divisor = cfg.cyc;
      end
      S_MUL_GAIN: begin
        mul_a = sum_clamp;
        mul_b = MUL_B_W'(cfg.kp_mag);
      end
      S_CHECK: begin
        // Below saturation the gain product fits in the low bits.
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = cfg.valve;
      end
      S_DIV_VALVE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(mul_p[MUL_P_W-1:SCALE_SHIFT]);
        div_req.divisor  = SCALE_ODD;
      end
      default: ;
    endcase
  end

  // Control state, error history and the output register's valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_err_q  <= '0;
      older_err_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // The history shifts on every transaction, dead band or not.
      if (accept) begin
        older_err_q <= last_err_q;
        last_err_q  <= e1_in;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          e1_q  <= e1_in;
          e2_q  <= last_err_q;
          e3_q  <= older_err_q;
          res_q <= '0;
          neg_q <= 1'b0;
        end
      end
      S_MUL_INT: diff_q <= 19'(e1_q) - 19'(e2_q) - 19'(e2_q) + 19'(e3_q);
      S_WAIT_INT: begin
        // Quotients truncate toward zero: divide magnitudes and restore the sign.
        if (div_done) begin
          qi_q <= e2_q[16] ? -quot_mag : quot_mag;
        end
      end
      S_WAIT_DER: begin
        if (div_done) begin
          qd_q <= diff_q[18] ? -quot_mag : quot_mag;
        end
      end
      S_SUM:      sum_q <= SUM_W'(e1_q) - SUM_W'(e2_q) + qi_q + qd_q;
      S_MUL_GAIN: neg_q <= cfg.kp_neg ^ sum_q[SUM_W-1];
      S_CHECK: begin
        if (sat) begin
          res_q <= cfg.valve;
        end
      end
      S_WAIT_VALVE: begin
        if (div_done) begin
          res_q <= div_quot[17:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_pulse_q <= pulse;
    end
  end

endmodule

@@ rtl/ipv_regs.sv @@
// Configuration register file with the clamping applied on use.
module ipv_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  ipv_pkg::cfg_idx_t  cfg_idx_i,
  input  ipv_pkg::cfg_data_t cfg_data_i,
  output ipv_pkg::cfg_t      cfg_o
);
  import ipv_pkg::*;

  logic signed [15:0] gain_q;
  logic [16:0]        ti_q;
  logic [16:0]        td_q;
  logic [17:0]        cyc_q;
  logic [17:0]        valve_q;
  logic [15:0]        db_q;
  logic signed [15:0] kp_clamped;
  logic signed [15:0] kp_negated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_P_RST;
      ti_q    <= TI_RST;
      td_q    <= TD_RST;
      cyc_q   <= CYC_RST;
      valve_q <= VALVE_RST;
      db_q    <= DEAD_BAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_P:          gain_q  <= $signed(cfg_data_i[15:0]);
        REG_INTEGRAL_TIME:   ti_q    <= cfg_data_i[16:0];
        REG_DERIVATIVE_TIME: td_q    <= cfg_data_i[16:0];
        REG_CYCLE_TIME:      cyc_q   <= cfg_data_i;
        REG_VALVE_TRAVEL:    valve_q <= cfg_data_i;
        REG_DEAD_BAND:       db_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gain_q > KP_LIMIT) begin
      kp_clamped = KP_LIMIT;
    end else if (gain_q < -KP_LIMIT) begin
      kp_clamped = -KP_LIMIT;
    end else begin
      kp_clamped = gain_q;
    end
    kp_negated   = -kp_clamped;
    cfg_o.kp_neg = kp_clamped[15];
    cfg_o.kp_mag = kp_clamped[15] ? kp_negated[14:0] : kp_clamped[14:0];

    // A zero integral time stands for the longest one.
    if (ti_q == '0 || ti_q > TI_MAX) begin
      cfg_o.ti = TI_MAX;
    end else if (ti_q < TI_MIN) begin
      cfg_o.ti = TI_MIN;
    end else begin
      cfg_o.ti = ti_q;
    end

    cfg_o.td = (td_q > TD_MAX) ? TD_MAX : td_q;

    if (cyc_q < CYC_MIN) begin
      cfg_o.cyc = CYC_MIN;
    end else if (cyc_q > CYC_MAX) begin
      cfg_o.cyc = CYC_MAX;
    end else begin
      cfg_o.cyc = cyc_q;
    end

    if (valve_q < VALVE_MIN) begin
      cfg_o.valve = VALVE_MIN;
    end else if (valve_q > VALVE_MAX) begin
      cfg_o.valve = VALVE_MAX;
    end else begin
      cfg_o.valve = valve_q;
    end

    cfg_o.dead_band = db_q;
  end

endmodule

@@ rtl/ipv_mul.sv @@
// Shared unsigned multiplier with a registered product.
module ipv_mul (
  input  logic            clk_i,
  input  ipv_pkg::mul_a_t a_i,
  input  ipv_pkg::mul_b_t b_i,
  output ipv_pkg::mul_p_t prod_o
);
  import ipv_pkg::*;

  mul_p_t prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/ipv_div.sv @@
// Shared restoring divider that retires two quotient bits per cycle.
module ipv_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipv_pkg::div_req_t req_i,
  output logic              done_o,
  output ipv_pkg::div_n_t   quot_o
);
  import ipv_pkg::*;

  div_n_t               num_q;
  div_n_t               num_v;
  div_d_t               rem_q;
  div_d_t               rem_v;
  div_d_t               den_q;
  logic [DIV_D_W:0]     trial;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;

  // The dividend register shifts out at the top and collects quotient bits at the bottom.
  always_comb begin
    rem_v = rem_q;
    num_v = num_q;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_v, num_v[DIV_N_W-1]};
      num_v = {num_v[DIV_N_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        num_v[0] = 1'b1;
      end
      rem_v = trial[DIV_D_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= DIV_STEPS;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == DIV_CNT_W'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      num_q <= num_v;
      rem_q <= rem_v;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

@@ rtl/ipv_chk.sv @@
// Port-level checker for the incremental PID valve pulse unit and its bind.
module ipv_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [18:0] pulse_ms_i
);

  // The block is busy right after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("ready stayed high after an input transaction");

  // Ready only drops because a transaction was accepted.
  a_ready_falls_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("ready dropped without an input transaction");

  // A new result shows up exactly when the block returns to idle.
  a_result_with_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result appeared while the block was still busy");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(pulse_ms_i)))
    else $error("stalled result changed or was dropped");

endmodule

bind incremental_pid_valve_pulse_unit ipv_chk u_ipv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pulse_ms_i  (out_o.pulse_ms)
);
